@@ design/fm_pll_demodulator_defines.svh @@
// ----------------------------------------------------------------------------
// FM PLL demodulator assertion macros
// Shared assertion forms for the demodulator's own checks.
// ----------------------------------------------------------------------------
`ifndef FM_PLL_DEMODULATOR_DEFINES_SVH
`define FM_PLL_DEMODULATOR_DEFINES_SVH

// Antecedent holds at an edge, consequent holds at the same edge.
`define FMPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fm_pll_demodulator same-cycle check failed");

// Antecedent holds at an edge, consequent holds at the next edge.
`define FMPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fm_pll_demodulator next-cycle check failed");

`endif

@@ design/fmpd_pkg.sv @@
// ----------------------------------------------------------------------------
// FM PLL demodulator package
// Sequencer states, register indexes, arctangent table, saturation helpers.
// ----------------------------------------------------------------------------
package fmpd_pkg;

    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_W         = 36;

    localparam logic [15:0] PROP_GAIN_RST  = 16'd37055;
    localparam logic [15:0] INTEG_GAIN_RST = 16'd7615;
    localparam logic [31:0] MIN_FREQ_RST   = 32'hEAAA_AAAB;
    localparam logic [31:0] MAX_FREQ_RST   = 32'h1555_5555;
    localparam logic [23:0] DC_KEEP_RST    = 24'd16759749;
    localparam logic [23:0] DC_TAKE_RST    = 24'd17467;
    localparam logic [23:0] AUDIO_GAIN_RST = 24'd629146;

    typedef enum logic [2:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_MIN_FREQ   = 3'd2,
        REG_MAX_FREQ   = 3'd3,
        REG_DC_KEEP    = 3'd4,
        REG_DC_TAKE    = 3'd5,
        REG_AUDIO_GAIN = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_MUL_INTEG,
        S_MUL_PROP,
        S_MUL_KEEP,
        S_MUL_TAKE,
        S_DC,
        S_MUL_AUDIO,
        S_AUDIO
    } t_state;

    function automatic logic [31:0] atan_lut(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            5'd24: v = 32'h0000_0029;
            5'd25: v = 32'h0000_0014;
            5'd26: v = 32'h0000_000A;
            5'd27: v = 32'h0000_0005;
            5'd28: v = 32'h0000_0003;
            5'd29: v = 32'h0000_0001;
            5'd30: v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat_s32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) r = 32'sh7FFF_FFFF;
        else if (x < -64'sd2147483648) r = 32'sh8000_0000;
        else r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat_s16(input logic signed [63:0] x);
        logic signed [15:0] r;
        if (x > 64'sd32767) r = 16'sh7FFF;
        else if (x < -64'sd32768) r = 16'sh8000;
        else r = x[15:0];
        return r;
    endfunction

endpackage

@@ design/fm_pll_demodulator.sv @@
// ----------------------------------------------------------------------------
// FM PLL demodulator
// Phase-locked FM discriminator with CORDIC phase detector, clamped
// second-order loop, DC tracker and saturated audio output.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                         Content
// s_*       in   s_tvalid/s_tready/s_tdata       one I/Q sample request
// m_*       out  m_tvalid/m_tready/m_tdata       one audio sample request
// cfg       in   i_cfg_we/i_cfg_idx/i_cfg_wdata  loop and gain registers
//
// A sample passes through N = min(CORDIC_STEPS,32) CORDIC iterations on the one
// shared add/shift unit and then five passes through the shared 33x25 multiplier
// before its result is loaded; the next sample is taken only once the sequencer
// is back in the idle state.
// s_tready is high only in the idle state.  A finished sample waits in the
// output register; the sequencer holds before loading it while the previous
// one is still not taken.  Reset (synchronous, active low) clears the loop
// state and loads the default register values.
// ----------------------------------------------------------------------------
`include "fm_pll_demodulator_defines.svh"

module fm_pll_demodulator #(
    parameter int SAMPLE_BITS  = fmpd_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = fmpd_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [15:0] in_phase, [31:16] quadrature
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [15:0] audio_out
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    localparam int CW    = fmpd_pkg::CORDIC_W;
    localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam logic [4:0] LAST_K = 5'(NSTEP - 1);

    // configuration
    logic        [15:0] r_prop_gain, r_integ_gain;
    logic signed [31:0] r_min_freq, r_max_freq;
    logic        [23:0] r_dc_keep, r_dc_take, r_audio_gain;

    // loop state
    logic        [31:0] r_osc;
    logic signed [31:0] r_fi, r_loop, r_dc;

    // sequencer and datapath
    fmpd_pkg::t_state r_state, n_state;
    logic        [4:0]    r_k;
    logic signed [CW-1:0] r_x, r_y;
    logic        [31:0]   r_z;
    logic                 r_zero;
    logic signed [31:0]   r_det;
    logic signed [57:0]   r_prod, r_acc;
    logic        [15:0]   r_out;
    logic                 r_ovalid;

    // input unpacking: low SAMPLE_BITS of each field, scaled to 32-bit range
    logic [23:0]          in_i_w, in_q_w;
    logic signed [31:0]   in_i_s, in_q_s;
    logic signed [CW-1:0] in_x, in_y;
    logic                 accept;

    always_comb begin
        in_i_w = {8'd0, s_tdata[15:0]};
        in_q_w = {8'd0, s_tdata[31:16]};
        in_i_s = signed'({in_i_w[SAMPLE_BITS-1:0], {(32-SAMPLE_BITS){1'b0}}});
        in_q_s = signed'({in_q_w[SAMPLE_BITS-1:0], {(32-SAMPLE_BITS){1'b0}}});
        in_x   = CW'(in_i_s);
        in_y   = CW'(in_q_s);
    end

    assign accept = s_tvalid && s_tready;

    // shared CORDIC micro-rotation
    logic signed [CW-1:0] x_sh, y_sh, x_nx, y_nx;
    logic        [31:0]   z_nx;
    always_comb begin
        x_sh = r_x >>> r_k;
        y_sh = r_y >>> r_k;
        if (r_y > 0) begin
            x_nx = r_x + y_sh;
            y_nx = r_y - x_sh;
            z_nx = r_z + fmpd_pkg::atan_lut(r_k);
        end else begin
            x_nx = r_x - y_sh;
            y_nx = r_y + x_sh;
            z_nx = r_z - fmpd_pkg::atan_lut(r_k);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fmpd_pkg::S_IDLE:      if (accept) n_state = fmpd_pkg::S_CORDIC;
            fmpd_pkg::S_CORDIC:    if (r_k == LAST_K) n_state = fmpd_pkg::S_MUL_INTEG;
            fmpd_pkg::S_MUL_INTEG: n_state = fmpd_pkg::S_MUL_PROP;
            fmpd_pkg::S_MUL_PROP:  n_state = fmpd_pkg::S_MUL_KEEP;
            fmpd_pkg::S_MUL_KEEP:  n_state = fmpd_pkg::S_MUL_TAKE;
            fmpd_pkg::S_MUL_TAKE:  n_state = fmpd_pkg::S_DC;
            fmpd_pkg::S_DC:        n_state = fmpd_pkg::S_MUL_AUDIO;
            fmpd_pkg::S_MUL_AUDIO: n_state = fmpd_pkg::S_AUDIO;
            fmpd_pkg::S_AUDIO:     if (!r_ovalid || m_tready) n_state = fmpd_pkg::S_IDLE;
            default:               n_state = fmpd_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake and multiplier operand select
    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    always_comb begin
        s_tready = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (r_state)
            fmpd_pkg::S_IDLE: begin
                s_tready = 1'b1;
            end
            fmpd_pkg::S_MUL_INTEG: begin
                mul_a = 33'(r_det);
                mul_b = signed'({9'd0, r_integ_gain});
            end
            fmpd_pkg::S_MUL_PROP: begin
                mul_a = 33'(r_det);
                mul_b = signed'({9'd0, r_prop_gain});
            end
            fmpd_pkg::S_MUL_KEEP: begin
                mul_a = 33'(r_dc);
                mul_b = signed'({1'b0, r_dc_keep});
            end
            fmpd_pkg::S_MUL_TAKE: begin
                mul_a = 33'(r_loop);
                mul_b = signed'({1'b0, r_dc_take});
            end
            fmpd_pkg::S_MUL_AUDIO: begin
                mul_a = 33'(r_loop) - 33'(r_dc);
                mul_b = signed'({1'b0, r_audio_gain});
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // shared multiplier
    logic signed [57:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // loop arithmetic around the registered product
    logic signed [33:0] w_sum, w_clamp, f_sum;
    logic signed [58:0] dc_sum;
    always_comb begin
        w_sum = 34'(r_fi) + 34'($signed(r_prod[48:16]));
        w_clamp = w_sum;
        if (w_clamp < 34'(r_min_freq)) w_clamp = 34'(r_min_freq);
        if (w_clamp > 34'(r_max_freq)) w_clamp = 34'(r_max_freq);
        f_sum  = 34'($signed(r_prod[48:16])) + 34'(r_fi);
        dc_sum = 59'(r_acc) + 59'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fmpd_pkg::S_IDLE;
            r_ovalid     <= 1'b0;
            r_osc        <= '0;
            r_fi         <= '0;
            r_loop       <= '0;
            r_dc         <= '0;
            r_prop_gain  <= fmpd_pkg::PROP_GAIN_RST;
            r_integ_gain <= fmpd_pkg::INTEG_GAIN_RST;
            r_min_freq   <= signed'(fmpd_pkg::MIN_FREQ_RST);
            r_max_freq   <= signed'(fmpd_pkg::MAX_FREQ_RST);
            r_dc_keep    <= fmpd_pkg::DC_KEEP_RST;
            r_dc_take    <= fmpd_pkg::DC_TAKE_RST;
            r_audio_gain <= fmpd_pkg::AUDIO_GAIN_RST;
        end else begin
            r_state <= n_state;

            // register writes; unknown indexes drop
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fmpd_pkg::REG_PROP_GAIN:  r_prop_gain  <= i_cfg_wdata[15:0];
                    fmpd_pkg::REG_INTEG_GAIN: r_integ_gain <= i_cfg_wdata[15:0];
                    fmpd_pkg::REG_MIN_FREQ:   r_min_freq   <= signed'(i_cfg_wdata);
                    fmpd_pkg::REG_MAX_FREQ:   r_max_freq   <= signed'(i_cfg_wdata);
                    fmpd_pkg::REG_DC_KEEP:    r_dc_keep    <= i_cfg_wdata[23:0];
                    fmpd_pkg::REG_DC_TAKE:    r_dc_take    <= i_cfg_wdata[23:0];
                    fmpd_pkg::REG_AUDIO_GAIN: r_audio_gain <= i_cfg_wdata[23:0];
                    default: ;
                endcase
            end

            if (r_ovalid && m_tready) r_ovalid <= 1'b0;

            case (r_state)
                fmpd_pkg::S_IDLE: begin
                    // turn left half-plane samples by pi before iterating
                    if (accept) begin
                        r_k    <= '0;
                        r_zero <= (in_i_s == 0) && (in_q_s == 0);
                        if (in_x < 0) begin
                            r_x <= -in_x;
                            r_y <= -in_y;
                            r_z <= 32'h8000_0000;
                        end else begin
                            r_x <= in_x;
                            r_y <= in_y;
                            r_z <= '0;
                        end
                    end
                end
                fmpd_pkg::S_CORDIC: begin
                    r_x <= x_nx;
                    r_y <= y_nx;
                    r_z <= z_nx;
                    r_k <= r_k + 5'd1;
                    // phase error is the angle less the oscillator phase
                    r_det <= r_zero ? 32'sd0 : signed'(z_nx - r_osc);
                end
                fmpd_pkg::S_MUL_INTEG: begin
                    r_prod <= mul_p;
                end
                fmpd_pkg::S_MUL_PROP: begin
                    r_prod <= mul_p;
                    r_fi   <= w_clamp[31:0];
                end
                fmpd_pkg::S_MUL_KEEP: begin
                    r_prod <= mul_p;
                    // oscillator advances by the previous loop output
                    r_osc  <= r_osc + r_loop;
                    r_loop <= fmpd_pkg::sat_s32(64'(f_sum));
                end
                fmpd_pkg::S_MUL_TAKE: begin
                    r_prod <= mul_p;
                    r_acc  <= r_prod;
                end
                fmpd_pkg::S_DC: begin
                    r_dc <= fmpd_pkg::sat_s32(64'($signed(dc_sum[58:24])));
                end
                fmpd_pkg::S_MUL_AUDIO: begin
                    r_prod <= mul_p;
                end
                fmpd_pkg::S_AUDIO: begin
                    if (!r_ovalid || m_tready) begin
                        r_out    <= fmpd_pkg::sat_s16(64'($signed(r_prod[57:32])));
                        r_ovalid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_out;

    // checks
    `FMPD_ASSERT_SAME(a_iter_bound, i_clk, i_rst_n, r_state == fmpd_pkg::S_CORDIC, r_k <= LAST_K)
    `FMPD_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, accept, r_state == fmpd_pkg::S_CORDIC)
    `FMPD_ASSERT_NEXT(a_result_from_seq, i_clk, i_rst_n, r_state != fmpd_pkg::S_AUDIO && !(r_ovalid && !m_tready), !m_tvalid)

endmodule
